/* sv/skeletal_vertex_skinning_bbox_top_macros.svh */
// Assertion helpers for the skinning block.
`ifndef SKELETAL_VERTEX_SKINNING_BBOX_TOP_MACROS_SVH
`define SKELETAL_VERTEX_SKINNING_BBOX_TOP_MACROS_SVH

// Check under reset qualification.
`define SVSB_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that also holds while reset is asserted.
`define SVSB_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* sv/svsb_pkg.sv */
package svsb_pkg;

    localparam int JOINT_COUNT = 64;
    localparam int JW          = $clog2(JOINT_COUNT);

    localparam int NUM_STEPS = 27;
    localparam int LAST_STEP = NUM_STEPS - 1;
    localparam int SW        = $clog2(NUM_STEPS);

    // Datapath widths
    localparam int TW   = 36;   // first product, rounded
    localparam int RW   = 40;   // rotated point plus joint position
    localparam int BW   = 18;   // multiplier b operand
    localparam int PW   = RW + BW;
    localparam int ACCW = 64;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_WEIGHT = 1'b1;

    typedef struct packed {
        logic               op;
        logic [5:0]         joint_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic [16:0]        bias;
        logic               last_weight;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        vertex_index;
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_y;
        logic signed [31:0] vert_z;
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
    } t_out_item;

    typedef enum logic [3:0] {
        A_PX, A_PY, A_PZ, A_TW, A_TX, A_TY, A_TZ, A_RX, A_RY, A_RZ
    } t_a_sel;

    typedef enum logic [2:0] {
        B_QX, B_QY, B_QZ, B_QW, B_BIAS
    } t_b_sel;

    typedef enum logic [3:0] {
        D_NONE, D_TW, D_TX, D_TY, D_TZ, D_RX, D_RY, D_RZ, D_AX, D_AY, D_AZ
    } t_dest;

    typedef struct packed {
        t_a_sel a_sel;
        t_b_sel b_sel;
        logic   neg;
        logic   first;
        t_dest  dest;
    } t_uop;

    // Program for one weight: q*p, then t*conj(q), then bias scaling.
    function automatic t_uop uop_rom(logic [SW-1:0] k);
        t_uop u;
        u = '{a_sel: A_PX, b_sel: B_QX, neg: 1'b0, first: 1'b0, dest: D_NONE};
        case (k)
            5'd0:  u = '{A_PX, B_QX, 1'b1, 1'b1, D_NONE};
            5'd1:  u = '{A_PY, B_QY, 1'b1, 1'b0, D_NONE};
            5'd2:  u = '{A_PZ, B_QZ, 1'b1, 1'b0, D_TW};
            5'd3:  u = '{A_PX, B_QW, 1'b0, 1'b1, D_NONE};
            5'd4:  u = '{A_PZ, B_QY, 1'b0, 1'b0, D_NONE};
            5'd5:  u = '{A_PY, B_QZ, 1'b1, 1'b0, D_TX};
            5'd6:  u = '{A_PY, B_QW, 1'b0, 1'b1, D_NONE};
            5'd7:  u = '{A_PX, B_QZ, 1'b0, 1'b0, D_NONE};
            5'd8:  u = '{A_PZ, B_QX, 1'b1, 1'b0, D_TY};
            5'd9:  u = '{A_PZ, B_QW, 1'b0, 1'b1, D_NONE};
            5'd10: u = '{A_PY, B_QX, 1'b0, 1'b0, D_NONE};
            5'd11: u = '{A_PX, B_QY, 1'b1, 1'b0, D_TZ};
            5'd12: u = '{A_TX, B_QW, 1'b0, 1'b1, D_NONE};
            5'd13: u = '{A_TW, B_QX, 1'b1, 1'b0, D_NONE};
            5'd14: u = '{A_TY, B_QZ, 1'b1, 1'b0, D_NONE};
            5'd15: u = '{A_TZ, B_QY, 1'b0, 1'b0, D_RX};
            5'd16: u = '{A_TY, B_QW, 1'b0, 1'b1, D_NONE};
            5'd17: u = '{A_TW, B_QY, 1'b1, 1'b0, D_NONE};
            5'd18: u = '{A_TZ, B_QX, 1'b1, 1'b0, D_NONE};
            5'd19: u = '{A_TX, B_QZ, 1'b0, 1'b0, D_RY};
            5'd20: u = '{A_TZ, B_QW, 1'b0, 1'b1, D_NONE};
            5'd21: u = '{A_TW, B_QZ, 1'b1, 1'b0, D_NONE};
            5'd22: u = '{A_TX, B_QY, 1'b1, 1'b0, D_NONE};
            5'd23: u = '{A_TY, B_QX, 1'b0, 1'b0, D_RZ};
            5'd24: u = '{A_RX, B_BIAS, 1'b0, 1'b1, D_AX};
            5'd25: u = '{A_RY, B_BIAS, 1'b0, 1'b1, D_AY};
            5'd26: u = '{A_RZ, B_BIAS, 1'b0, 1'b1, D_AZ};
            default: u = '{A_PX, B_QX, 1'b0, 1'b1, D_NONE};
        endcase
        return u;
    endfunction

endpackage

/* sv/skeletal_vertex_skinning_bbox_top.sv */
// Load item: written to the joint table; ready again on the next cycle.
// Weight item: 27 multiply steps on one shared 40x18 multiplier with a
// product register, then drain and finish. The input stays stalled until
// the weight is done, so a new item is not taken before the last one ends.
// Reset clears accumulators, vertex count and box; joint table is not reset.
module skeletal_vertex_skinning_bbox_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  svsb_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output svsb_pkg::t_out_item  o_out
);
    import svsb_pkg::*;
    `include "skeletal_vertex_skinning_bbox_top_macros.svh"

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_FIN} t_state;

    localparam logic signed [ACCW-1:0] SAT_MAX = ACCW'(64'sh7FFF_FFFF);
    localparam logic signed [ACCW-1:0] SAT_MIN = -ACCW'(64'sh8000_0000);

    t_state r_state;
    logic [SW-1:0] r_step;
    logic r_last;
    logic [16:0] r_bias;
    logic signed [31:0] r_px, r_py, r_pz;

    // Joint table
    logic [63:0] r_mem_q   [JOINT_COUNT];
    logic [63:0] r_mem_pxy [JOINT_COUNT];
    logic [31:0] r_mem_pz  [JOINT_COUNT];
    logic [63:0] r_rd_q, r_rd_pxy;
    logic [31:0] r_rd_pz;

    logic signed [TW-1:0] r_tw, r_tx, r_ty, r_tz;
    logic signed [RW-1:0] r_rx, r_ry, r_rz;
    logic signed [PW-1:0] r_prod;
    logic signed [ACCW-1:0] r_acc;
    t_uop r_ctl;
    logic r_ctl_valid;

    logic signed [31:0] r_accum_x, r_accum_y, r_accum_z;
    logic signed [31:0] r_low_x, r_low_y, r_low_z;
    logic signed [31:0] r_high_x, r_high_y, r_high_z;
    logic [15:0] r_vcount;
    logic r_out_valid;
    t_out_item r_out;

    logic in_acc;
    logic [JW-1:0] idx;
    logic signed [15:0] qx, qy, qz, qw;
    logic signed [31:0] jx, jy, jz;
    t_uop uop;
    logic signed [RW-1:0] op_a;
    logic signed [BW-1:0] op_b;
    logic signed [PW-1:0] mul;
    logic signed [ACCW-1:0] base, sum, rnd15, rnd16, asum;
    logic signed [31:0] acc_sel, jp_sel, sat_val;
    logic signed [31:0] n_low_x, n_low_y, n_low_z, n_high_x, n_high_y, n_high_z;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign idx         = i_in.joint_index[JW-1:0];
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign qx = r_rd_q[63:48];
    assign qy = r_rd_q[47:32];
    assign qz = r_rd_q[31:16];
    assign qw = r_rd_q[15:0];
    assign jx = r_rd_pxy[63:32];
    assign jy = r_rd_pxy[31:0];
    assign jz = r_rd_pz;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (i_in.op == OP_LOAD) begin
                r_mem_q[idx]   <= {i_in.quat_x, i_in.quat_y, i_in.quat_z, i_in.quat_w};
                r_mem_pxy[idx] <= {i_in.pos_x, i_in.pos_y};
                r_mem_pz[idx]  <= i_in.pos_z;
            end
            r_rd_q   <= r_mem_q[idx];
            r_rd_pxy <= r_mem_pxy[idx];
            r_rd_pz  <= r_mem_pz[idx];
        end
    end

    // Shared multiplier
    always_comb begin
        uop = uop_rom(r_step);
        case (uop.a_sel)
            A_PX:    op_a = RW'(r_px);
            A_PY:    op_a = RW'(r_py);
            A_PZ:    op_a = RW'(r_pz);
            A_TW:    op_a = RW'(r_tw);
            A_TX:    op_a = RW'(r_tx);
            A_TY:    op_a = RW'(r_ty);
            A_TZ:    op_a = RW'(r_tz);
            A_RX:    op_a = r_rx;
            A_RY:    op_a = r_ry;
            A_RZ:    op_a = r_rz;
            default: op_a = '0;
        endcase
        case (uop.b_sel)
            B_QX:    op_b = BW'(qx);
            B_QY:    op_b = BW'(qy);
            B_QZ:    op_b = BW'(qz);
            B_QW:    op_b = BW'(qw);
            B_BIAS:  op_b = signed'({1'b0, r_bias});
            default: op_b = '0;
        endcase
        mul = op_a * op_b;
    end

    // Accumulate and write back
    always_comb begin
        base  = r_ctl.first ? '0 : r_acc;
        sum   = r_ctl.neg ? base - ACCW'(r_prod) : base + ACCW'(r_prod);
        rnd15 = (sum + ACCW'(64'sd16384)) >>> 15;
        rnd16 = (sum + ACCW'(64'sd32768)) >>> 16;
        case (r_ctl.dest)
            D_AY:    acc_sel = r_accum_y;
            D_AZ:    acc_sel = r_accum_z;
            default: acc_sel = r_accum_x;
        endcase
        case (r_ctl.dest)
            D_RY:    jp_sel = jy;
            D_RZ:    jp_sel = jz;
            default: jp_sel = jx;
        endcase
        asum = ACCW'(acc_sel) + rnd16;
        if (asum > SAT_MAX) begin
            sat_val = 32'sh7FFF_FFFF;
        end else if (asum < SAT_MIN) begin
            sat_val = -32'sh8000_0000;
        end else begin
            sat_val = asum[31:0];
        end
    end

    always_comb begin
        n_low_x  = (r_accum_x < r_low_x)  ? r_accum_x : r_low_x;
        n_low_y  = (r_accum_y < r_low_y)  ? r_accum_y : r_low_y;
        n_low_z  = (r_accum_z < r_low_z)  ? r_accum_z : r_low_z;
        n_high_x = (r_accum_x > r_high_x) ? r_accum_x : r_high_x;
        n_high_y = (r_accum_y > r_high_y) ? r_accum_y : r_high_y;
        n_high_z = (r_accum_z > r_high_z) ? r_accum_z : r_high_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_ctl_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_accum_x   <= '0;
            r_accum_y   <= '0;
            r_accum_z   <= '0;
            r_vcount    <= '0;
            r_low_x     <= 32'sh7FFF_FFFF;
            r_low_y     <= 32'sh7FFF_FFFF;
            r_low_z     <= 32'sh7FFF_FFFF;
            r_high_x    <= -32'sh8000_0000;
            r_high_y    <= -32'sh8000_0000;
            r_high_z    <= -32'sh8000_0000;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_ctl_valid) begin
                r_acc <= sum;
                case (r_ctl.dest)
                    D_TW:    r_tw <= TW'(rnd15);
                    D_TX:    r_tx <= TW'(rnd15);
                    D_TY:    r_ty <= TW'(rnd15);
                    D_TZ:    r_tz <= TW'(rnd15);
                    D_RX:    r_rx <= RW'(rnd15) + RW'(jp_sel);
                    D_RY:    r_ry <= RW'(rnd15) + RW'(jp_sel);
                    D_RZ:    r_rz <= RW'(rnd15) + RW'(jp_sel);
                    D_AX:    r_accum_x <= sat_val;
                    D_AY:    r_accum_y <= sat_val;
                    D_AZ:    r_accum_z <= sat_val;
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_px   <= i_in.pos_x;
                        r_py   <= i_in.pos_y;
                        r_pz   <= i_in.pos_z;
                        r_bias <= i_in.bias;
                        r_last <= i_in.last_weight;
                        r_step <= '0;
                        if (i_in.op == OP_WEIGHT) begin
                            r_state <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    r_prod      <= mul;
                    r_ctl       <= uop;
                    r_ctl_valid <= 1'b1;
                    if (r_step == SW'(LAST_STEP)) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    r_ctl_valid <= 1'b0;
                    r_state     <= ST_FIN;
                end
                ST_FIN: begin
                    if (!r_last) begin
                        r_state <= ST_IDLE;
                    end else if (!r_out_valid || !i_out_stall) begin
                        // emit vertex, fold it into the box, start the next vertex
                        r_out_valid        <= 1'b1;
                        r_out.vertex_index <= r_vcount;
                        r_out.vert_x       <= r_accum_x;
                        r_out.vert_y       <= r_accum_y;
                        r_out.vert_z       <= r_accum_z;
                        r_out.box_min_x    <= n_low_x;
                        r_out.box_min_y    <= n_low_y;
                        r_out.box_min_z    <= n_low_z;
                        r_out.box_max_x    <= n_high_x;
                        r_out.box_max_y    <= n_high_y;
                        r_out.box_max_z    <= n_high_z;
                        r_low_x            <= n_low_x;
                        r_low_y            <= n_low_y;
                        r_low_z            <= n_low_z;
                        r_high_x           <= n_high_x;
                        r_high_y           <= n_high_y;
                        r_high_z           <= n_high_z;
                        r_vcount           <= r_vcount + 1'b1;
                        r_accum_x          <= '0;
                        r_accum_y          <= '0;
                        r_accum_z          <= '0;
                        r_state            <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `SVSB_CHECK(a_emit_from_fin, $rose(r_out_valid) |-> $past(r_state) == ST_FIN, "item emitted outside finish")
    `SVSB_CHECK(a_step_bound, r_step <= SW'(LAST_STEP), "step counter out of range")
    `SVSB_CHECK(a_box_order, r_out_valid |-> (r_out.box_min_x <= r_out.box_max_x) && (r_out.box_min_y <= r_out.box_max_y) && (r_out.box_min_z <= r_out.box_max_z), "box min above max")
    `SVSB_CHECK(a_accum_cleared, $rose(r_out_valid) |-> (r_accum_x == '0) && (r_accum_y == '0) && (r_accum_z == '0), "accumulator not cleared on emit")
    `SVSB_CHECK_ALWAYS(a_idle_quiet, (r_state == ST_IDLE) && i_rst_n |=> !r_ctl_valid || !i_rst_n, "accumulate while idle")

endmodule
